// ----- hdl/cpr_pkg.sv -----
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants of the clock page replacer: ring sizes, request
// kinds, sequencer states and the request and result beat layouts.
// ----------------------------------------------------------------------------
package cpr_pkg;

    // ring and frame table sizes
    localparam int SLOT_COUNT  = 64;
    localparam int FRAME_COUNT = 64;

    // field widths fixed by the interface
    localparam int KIND_W      = 2;
    localparam int FRAME_NUM_W = 6;
    localparam int COUNT_W     = 7;

    // index widths
    localparam int SLOT_AW  = $clog2(SLOT_COUNT);
    localparam int FRAME_AW = FRAME_NUM_W;

    // register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ACTIVE_SLOTS = 1'b0;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_VICTIM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PIN    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNPIN  = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VICTIM,
        ST_VICTIM_RD,
        ST_PIN_RD,
        ST_UNPIN,
        ST_FINISH
    } state_t;

    // request beat
    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [FRAME_NUM_W-1:0] frame_num;
    } req_t;

    // result beat
    typedef struct packed {
        logic                   found;
        logic [FRAME_NUM_W-1:0] victim_frame;
        logic [COUNT_W-1:0]     evictable_count;
    } rsp_t;

endpackage

// ----- hdl/cpr_ram.sv -----
// ----------------------------------------------------------------------------
// cpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/clock_page_replacer.sv -----
// ----------------------------------------------------------------------------
// clock_page_replacer
// Clock (second-chance) page replacer over a ring of up to 64 slots.
// ----------------------------------------------------------------------------
// Usage:
//   s_data carries one request beat (kind, frame_num): victim, pin or unpin.
//   m_data returns one result beat per request (found, victim_frame,
//   evictable_count). Both channels use valid/ready.
//   active_slots sits at APB address 0; writing it empties the ring.
//   Write it only while no request is in flight.
// Timing:
//   one request at a time; s_ready is high only while the sequencer idles.
//   after the accept, ignored requests go straight to ST_FINISH; pin first
//   reads the frame's slot in ST_PIN_RD. unpin steps from the hand to the
//   first free slot in ST_UNPIN. victim sweeps the hand in ST_VICTIM to the
//   evicted slot, then reads its frame id in ST_VICTIM_RD. ST_FINISH loads
//   the result beat. The hand advances one slot a cycle through the
//   valid and use bit vectors; frame ids come from a registered RAM read.
// Reset and stall:
//   reset empties the ring, sets the hand to slot 0 and active_slots to 64.
//   the result waits in an output register while m_ready is low; the next
//   request can be accepted meanwhile, but its result waits for that slot.
// ----------------------------------------------------------------------------
module clock_page_replacer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cpr_pkg::req_t                   s_data,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output cpr_pkg::rsp_t                   m_data,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cpr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cpr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cpr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    cpr_pkg::state_t state_reg, state_next;

    logic [cpr_pkg::COUNT_W-1:0]     active_reg, active_next;
    logic [cpr_pkg::SLOT_COUNT-1:0]  valid_reg, valid_next;
    logic [cpr_pkg::SLOT_COUNT-1:0]  use_reg, use_next;
    logic [cpr_pkg::FRAME_COUNT-1:0] present_reg, present_next;
    logic [cpr_pkg::SLOT_AW-1:0]     hand_reg, hand_next;
    logic [cpr_pkg::COUNT_W-1:0]     held_reg, held_next;
    logic [cpr_pkg::SLOT_AW-1:0]     scan_reg, scan_next;
    logic [cpr_pkg::FRAME_NUM_W-1:0] fid_reg, fid_next;
    logic                            found_reg, found_next;
    logic [cpr_pkg::FRAME_NUM_W-1:0] vframe_reg, vframe_next;
    logic                            m_valid_reg, m_valid_next;
    cpr_pkg::rsp_t                   m_data_reg, m_data_next;

    logic                            s_accept;
    logic                            cfg_wr;
    logic                            out_free;
    logic                            fid_ok;
    logic [cpr_pkg::COUNT_W-1:0]     cfg_value;
    logic [cpr_pkg::SLOT_AW-1:0]     hand_step;
    logic [cpr_pkg::SLOT_AW-1:0]     scan_step;
    logic [cpr_pkg::SLOT_AW-1:0]     pin_slot;

    // slot to frame memory
    logic                            sf_wr_en;
    logic [cpr_pkg::FRAME_NUM_W-1:0] sf_rd_data;
    // frame to slot memory
    logic                            fs_wr_en;
    logic [cpr_pkg::FRAME_AW-1:0]    fs_rd_addr;
    logic [cpr_pkg::SLOT_AW-1:0]     fs_rd_data;

    // advance a slot index around the active part of the ring
    function automatic logic [cpr_pkg::SLOT_AW-1:0] ring_next(
        input logic [cpr_pkg::SLOT_AW-1:0] s,
        input logic [cpr_pkg::COUNT_W-1:0] active
    );
        logic [cpr_pkg::COUNT_W-1:0] n;
        n = cpr_pkg::COUNT_W'(s) + cpr_pkg::COUNT_W'(1);
        return (n >= active) ? '0 : n[cpr_pkg::SLOT_AW-1:0];
    endfunction

    // handshakes
    assign s_ready  = (state_reg == cpr_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == cpr_pkg::REG_ACTIVE_SLOTS);
    assign prdata = (paddr[2] == cpr_pkg::REG_ACTIVE_SLOTS)
                    ? cpr_pkg::APB_DATA_W'(active_reg) : '0;

    // clamp the written slot count into 1..SLOT_COUNT
    always_comb begin
        cfg_value = pwdata[cpr_pkg::COUNT_W-1:0];
        if (cfg_value == '0) begin
            cfg_value = cpr_pkg::COUNT_W'(1);
        end else if (32'(cfg_value) > cpr_pkg::SLOT_COUNT) begin
            cfg_value = cpr_pkg::COUNT_W'(cpr_pkg::SLOT_COUNT);
        end
    end

    assign fid_ok    = (32'(s_data.frame_num) < cpr_pkg::FRAME_COUNT);
    assign hand_step = ring_next(hand_reg, active_reg);
    assign scan_step = ring_next(scan_reg, active_reg);
    assign pin_slot  = fs_rd_data;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cpr_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = cpr_pkg::ST_FINISH;
                    if (s_data.kind == cpr_pkg::KIND_VICTIM && held_reg != '0) begin
                        state_next = cpr_pkg::ST_VICTIM;
                    end else if (s_data.kind == cpr_pkg::KIND_PIN && fid_ok
                                 && present_reg[s_data.frame_num]) begin
                        state_next = cpr_pkg::ST_PIN_RD;
                    end else if (s_data.kind == cpr_pkg::KIND_UNPIN && fid_ok
                                 && !present_reg[s_data.frame_num]
                                 && held_reg < active_reg) begin
                        state_next = cpr_pkg::ST_UNPIN;
                    end
                end
            end
            cpr_pkg::ST_VICTIM: begin
                if (valid_reg[hand_reg] && !use_reg[hand_reg]) begin
                    state_next = cpr_pkg::ST_VICTIM_RD;
                end
            end
            cpr_pkg::ST_VICTIM_RD: state_next = cpr_pkg::ST_FINISH;
            cpr_pkg::ST_PIN_RD:    state_next = cpr_pkg::ST_FINISH;
            cpr_pkg::ST_UNPIN: begin
                if (!valid_reg[scan_reg]) begin
                    state_next = cpr_pkg::ST_FINISH;
                end
            end
            cpr_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = cpr_pkg::ST_IDLE;
                end
            end
            default: state_next = cpr_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        active_next  = active_reg;
        valid_next   = valid_reg;
        use_next     = use_reg;
        present_next = present_reg;
        hand_next    = hand_reg;
        held_next    = held_reg;
        scan_next    = scan_reg;
        fid_next     = fid_reg;
        found_next   = found_reg;
        vframe_next  = vframe_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        sf_wr_en     = 1'b0;
        fs_wr_en     = 1'b0;
        fs_rd_addr   = s_data.frame_num;

        unique case (state_reg)
            cpr_pkg::ST_IDLE: begin
                // capture the request beat
                if (s_accept) begin
                    fid_next    = s_data.frame_num;
                    found_next  = 1'b0;
                    vframe_next = '0;
                    scan_next   = hand_reg;
                end
            end
            cpr_pkg::ST_VICTIM: begin
                // one slot per cycle: skip an empty slot, clear a use bit or evict
                hand_next = hand_step;
                if (valid_reg[hand_reg]) begin
                    if (use_reg[hand_reg]) begin
                        use_next[hand_reg] = 1'b0;
                    end else begin
                        valid_next[hand_reg] = 1'b0;
                        held_next = held_reg - cpr_pkg::COUNT_W'(1);
                    end
                end
            end
            cpr_pkg::ST_VICTIM_RD: begin
                // evicted frame id arrives from the slot memory
                found_next   = 1'b1;
                vframe_next  = sf_rd_data;
                present_next[sf_rd_data] = 1'b0;
            end
            cpr_pkg::ST_PIN_RD: begin
                // slot of the pinned frame arrives from the frame memory
                present_next[fid_reg] = 1'b0;
                if (valid_reg[pin_slot]) begin
                    valid_next[pin_slot] = 1'b0;
                    use_next[pin_slot]   = 1'b0;
                    if (held_reg != '0) begin
                        held_next = held_reg - cpr_pkg::COUNT_W'(1);
                    end
                end
            end
            cpr_pkg::ST_UNPIN: begin
                // search for the first free slot from the hand
                if (!valid_reg[scan_reg]) begin
                    valid_next[scan_reg] = 1'b1;
                    use_next[scan_reg]   = 1'b1;
                    present_next[fid_reg] = 1'b1;
                    held_next = held_reg + cpr_pkg::COUNT_W'(1);
                    sf_wr_en  = 1'b1;
                    fs_wr_en  = 1'b1;
                end else begin
                    scan_next = scan_step;
                end
            end
            cpr_pkg::ST_FINISH: begin
                // load the result beat once the output register is free
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.found           = found_reg;
                    m_data_next.victim_frame    = vframe_reg;
                    m_data_next.evictable_count = held_reg;
                end
            end
            default: begin
            end
        endcase

        // slot count write empties the ring
        if (cfg_wr) begin
            active_next  = cfg_value;
            valid_next   = '0;
            use_next     = '0;
            present_next = '0;
            hand_next    = '0;
            held_next    = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cpr_pkg::ST_IDLE;
            active_reg  <= cpr_pkg::COUNT_W'(cpr_pkg::SLOT_COUNT);
            valid_reg   <= '0;
            use_reg     <= '0;
            present_reg <= '0;
            hand_reg    <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            valid_reg   <= valid_next;
            use_reg     <= use_next;
            present_reg <= present_next;
            hand_reg    <= hand_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        scan_reg   <= scan_next;
        fid_reg    <= fid_next;
        found_reg  <= found_next;
        vframe_reg <= vframe_next;
        m_data_reg <= m_data_next;
    end

    // frame id held in each slot, read at the hand
    cpr_ram #(
        .WIDTH (cpr_pkg::FRAME_NUM_W),
        .DEPTH (cpr_pkg::SLOT_COUNT)
    ) u_slot_frame_ram (
        .aclk    (aclk),
        .wr_en   (sf_wr_en),
        .wr_addr (scan_reg),
        .wr_data (fid_reg),
        .rd_addr (hand_reg),
        .rd_data (sf_rd_data)
    );

    // slot holding each frame, read at the requested frame
    cpr_ram #(
        .WIDTH (cpr_pkg::SLOT_AW),
        .DEPTH (cpr_pkg::FRAME_COUNT)
    ) u_frame_slot_ram (
        .aclk    (aclk),
        .wr_en   (fs_wr_en),
        .wr_addr (fid_reg),
        .wr_data (scan_reg),
        .rd_addr (fs_rd_addr),
        .rd_data (fs_rd_data)
    );

endmodule
